// File: src/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg: shared types and constants for the buzzer melody sequencer
// Field widths, request modes, status codes and the tone table word layout.
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned TITLE_W = 4;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned DUR_W   = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 3'd0,
    MODE_PLAY  = 3'd1,
    MODE_FREQ  = 3'd2,
    MODE_STOP  = 3'd3,
    MODE_WRITE = 3'd4
  } mode_e;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_TITLE = 1'b1;

  // One melody step: frequency in the upper half, duration in the lower half.
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } entry_t;

endpackage

// File: src/bms_if.sv
// ----------------------------------------------------------------------------
// bms_if: request and response channels of the buzzer melody sequencer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bms_req_if;
  logic                         valid;
  logic                         ready;
  logic [bms_pkg::MODE_W-1:0]   mode;
  logic [bms_pkg::TITLE_W-1:0]  title;
  logic [bms_pkg::INDEX_W-1:0]  entry_index;
  logic [bms_pkg::FREQ_W-1:0]   frequency;
  logic [bms_pkg::DUR_W-1:0]    duration_ms;

  modport source (output valid, mode, title, entry_index, frequency, duration_ms,
                  input ready);
  modport sink   (input valid, mode, title, entry_index, frequency, duration_ms,
                  output ready);
endinterface

interface bms_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        speaker_on;
  logic [bms_pkg::FREQ_W-1:0]  tone_frequency;
  logic                        playing;
  logic                        status;

  modport source (output valid, speaker_on, tone_frequency, playing, status,
                  input ready);
  modport sink   (input valid, speaker_on, tone_frequency, playing, status,
                  output ready);
endinterface

// File: src/bms_tone_table.sv
// ----------------------------------------------------------------------------
// bms_tone_table: melody step memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bms_tone_table #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/buzzer_melody_sequencer_core.sv
// ----------------------------------------------------------------------------
// buzzer_melody_sequencer_core: melody and tone sequencer for a buzzer
// Plays melodies from a tone table and single timed tones; handles stops, ticks and table writes.
// ----------------------------------------------------------------------------
// Path: accept, stage 1, then the response register. Throughput: one request
//   per cycle while the response is not stalled; each request uses the table's
//   single read port at most once, issued in the accept cycle.
// Reset: timer, title, step index and speaker drive clear at once; the tone
//   table is not cleared and holds no data until written. No startup sweep.
// ----------------------------------------------------------------------------
module buzzer_melody_sequencer_core #(
  parameter int unsigned MELODY_COUNT     = 16,
  parameter int unsigned STEPS_PER_MELODY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bms_req_if.sink    req_i,
  bms_rsp_if.source  rsp_o
);

  localparam int unsigned Depth  = MELODY_COUNT * STEPS_PER_MELODY;
  localparam int unsigned AddrW  = $clog2(Depth);
  // Step index must also hold STEPS_PER_MELODY (one past the last step).
  localparam int unsigned StepW  = $clog2(STEPS_PER_MELODY + 1);
  localparam int unsigned ProdN  = bms_pkg::TITLE_W + StepW + 1;
  localparam int unsigned ProdW  = (AddrW > ProdN) ? AddrW : ProdN;
  localparam int unsigned EntryW = $bits(bms_pkg::entry_t);

  localparam int unsigned TW = bms_pkg::TITLE_W;
  localparam int unsigned FW = bms_pkg::FREQ_W;
  localparam int unsigned DW = bms_pkg::DUR_W;

  // --------------------------------------------------------------------------
  // Pipeline: accept (table access) -> stage 1 (state update) -> response reg
  // --------------------------------------------------------------------------
  logic req_fire, s1_fire, out_free;

  logic              s1_v_q;
  bms_pkg::mode_e    s1_mode_q;
  logic [TW-1:0]     s1_title_q;
  logic [FW-1:0]     s1_freq_q;
  logic [DW-1:0]     s1_dur_q;

  logic              out_v_q;
  logic              out_spk_q;
  logic [FW-1:0]     out_freq_q;
  logic              out_play_q;
  logic              out_stat_q;

  // Architectural playback state
  logic [DW-1:0]     rem_q, rem_d;
  logic              active_q, active_d;
  logic [TW-1:0]     title_q, title_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              drive_on_q, drive_on_d;
  logic [FW-1:0]     drive_freq_q, drive_freq_d;
  logic              s1_status;

  // Output register frees up when empty or being drained this cycle.
  assign out_free    = !out_v_q || rsp_o.ready;
  assign s1_fire     = s1_v_q && out_free;
  assign req_i.ready = !s1_v_q || out_free;
  assign req_fire    = req_i.valid && req_i.ready;

  // --------------------------------------------------------------------------
  // Tone table
  // --------------------------------------------------------------------------
  bms_pkg::mode_e      req_mode;
  logic                mem_we, mem_re;
  logic [AddrW-1:0]    mem_waddr, mem_raddr;
  logic [ProdW-1:0]    wr_prod, rd_prod;
  logic [TW-1:0]       rd_title;
  logic [StepW-1:0]    rd_step;
  logic [EntryW-1:0]   mem_rdata;
  bms_pkg::entry_t     wr_entry, rd_entry;

  assign req_mode = bms_pkg::mode_e'(req_i.mode);

  // Writes land in the accept cycle; out-of-range titles or steps are dropped.
  assign mem_we = req_fire && (req_mode == bms_pkg::MODE_WRITE)
               && (32'(req_i.title) < MELODY_COUNT)
               && (32'(req_i.entry_index) < STEPS_PER_MELODY);
  assign wr_prod = ProdW'(req_i.title) * ProdW'(STEPS_PER_MELODY)
                 + ProdW'(req_i.entry_index);
  assign mem_waddr = wr_prod[AddrW-1:0];
  assign wr_entry.freq = req_i.frequency;
  assign wr_entry.dur  = req_i.duration_ms;

  // Read address for the incoming request. A play reads step 0 of the new
  // title. A tick reads the step that follows the state left by the request
  // now in stage 1 (title_d/step_d), so back-to-back requests see the update.
  // If that step turns out not to be needed (halt, no title), data is ignored.
  always_comb begin
    if (req_mode == bms_pkg::MODE_PLAY) begin
      rd_title = req_i.title;
      rd_step  = '0;
    end else begin
      rd_title = title_d;
      rd_step  = step_d;
    end
  end

  assign rd_prod   = ProdW'(rd_title) * ProdW'(STEPS_PER_MELODY) + ProdW'(rd_step);
  assign mem_raddr = rd_prod[AddrW-1:0];
  assign mem_re    = req_fire && ((req_mode == bms_pkg::MODE_TICK)
                               || (req_mode == bms_pkg::MODE_PLAY));

  bms_tone_table #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW),
    .DATA_W (EntryW)
  ) u_tone_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wr_entry),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_entry = bms_pkg::entry_t'(mem_rdata);

  // --------------------------------------------------------------------------
  // Stage 1: apply the request to the playback state
  // --------------------------------------------------------------------------
  logic [DW-1:0] rem_dec;
  logic          cur_title_ok, s1_title_ok, step_past_end, do_halt;

  assign rem_dec       = (rem_q != '0) ? rem_q - 1'b1 : '0;
  assign cur_title_ok  = 32'(title_q) < MELODY_COUNT;
  assign s1_title_ok   = 32'(s1_title_q) < MELODY_COUNT;
  assign step_past_end = 32'(step_q) >= STEPS_PER_MELODY;

  always_comb begin
    rem_d        = rem_q;
    active_d     = active_q;
    title_d      = title_q;
    step_d       = step_q;
    drive_on_d   = drive_on_q;
    drive_freq_d = drive_freq_q;
    s1_status    = bms_pkg::STATUS_OK;
    do_halt      = 1'b0;

    if (s1_fire) begin
      unique case (s1_mode_q)
        bms_pkg::MODE_TICK: begin
          if (active_q) begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              // Timer expiry: advance to the next melody step or stop.
              if (title_q == '0 || step_past_end) begin
                do_halt = 1'b1;
              end else begin
                step_d = step_q + 1'b1;
                // Titles past the table read as empty steps.
                if (!cur_title_ok || rd_entry.dur == '0) begin
                  do_halt = 1'b1;
                end else begin
                  drive_on_d   = rd_entry.freq != '0;
                  drive_freq_d = rd_entry.freq;
                  rem_d        = rd_entry.dur;
                  active_d     = 1'b1;
                end
              end
            end
          end
        end
        bms_pkg::MODE_PLAY: begin
          step_d = '0;
          if (s1_title_q == '0) begin
            do_halt   = 1'b1;
            s1_status = bms_pkg::STATUS_BAD_TITLE;
          end else begin
            // Speaker keeps its output; step 0 plays after its own duration.
            title_d  = s1_title_q;
            rem_d    = s1_title_ok ? rd_entry.dur : '0;
            active_d = 1'b1;
          end
        end
        bms_pkg::MODE_FREQ: begin
          // Title and step stay, so a melody resumes after this tone.
          drive_on_d   = s1_freq_q != '0;
          drive_freq_d = s1_freq_q;
          rem_d        = s1_dur_q;
          active_d     = 1'b1;
        end
        bms_pkg::MODE_STOP: begin
          do_halt = 1'b1;
        end
        bms_pkg::MODE_WRITE: begin
          // Table already written at accept.
        end
        default: begin
          // Unused codes leave everything as is.
        end
      endcase

      if (do_halt) begin
        drive_on_d   = 1'b0;
        drive_freq_d = '0;
        title_d      = '0;
        step_d       = '0;
        rem_d        = '0;
        active_d     = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      rem_q        <= '0;
      active_q     <= 1'b0;
      title_q      <= '0;
      step_q       <= '0;
      drive_on_q   <= 1'b0;
      drive_freq_q <= '0;
    end else begin
      if (req_fire) begin
        s1_v_q <= 1'b1;
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end

      if (s1_fire) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end

      rem_q        <= rem_d;
      active_q     <= active_d;
      title_q      <= title_d;
      step_q       <= step_d;
      drive_on_q   <= drive_on_d;
      drive_freq_q <= drive_freq_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_mode_q  <= req_mode;
      s1_title_q <= req_i.title;
      s1_freq_q  <= req_i.frequency;
      s1_dur_q   <= req_i.duration_ms;
    end
    if (s1_fire) begin
      out_spk_q  <= drive_on_d;
      out_freq_q <= drive_on_d ? drive_freq_d : '0;
      out_play_q <= active_d;
      out_stat_q <= s1_status;
    end
  end

  assign rsp_o.valid          = out_v_q;
  assign rsp_o.speaker_on     = out_spk_q;
  assign rsp_o.tone_frequency = out_freq_q;
  assign rsp_o.playing        = out_play_q;
  assign rsp_o.status         = out_stat_q;

endmodule

// File: src/bms_checker.sv
// ----------------------------------------------------------------------------
// bms_checker: response checks for the buzzer melody sequencer
// Watches the response channel and checks consistency of the reported state.
// ----------------------------------------------------------------------------
module bms_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        speaker_on_i,
  input logic [bms_pkg::FREQ_W-1:0]  tone_frequency_i,
  input logic                        playing_i,
  input logic                        status_i
);

  // Silent speaker always reports frequency zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !speaker_on_i |-> tone_frequency_i == '0)
    else $error("tone_frequency nonzero with speaker off");

  // The speaker is only driven while a melody or timed tone is active.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && speaker_on_i |-> playing_i)
    else $error("speaker on while not playing");

  // A rejected play request stops everything.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == bms_pkg::STATUS_BAD_TITLE) |-> !playing_i && !speaker_on_i)
    else $error("bad title status while still playing");

  // A stalled response holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(speaker_on_i)
      && $stable(tone_frequency_i) && $stable(playing_i) && $stable(status_i))
    else $error("response changed while stalled");

endmodule

bind buzzer_melody_sequencer_core bms_checker u_bms_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .speaker_on_i     (rsp_o.speaker_on),
  .tone_frequency_i (rsp_o.tone_frequency),
  .playing_i        (rsp_o.playing),
  .status_i         (rsp_o.status)
);
